// File: src/rc4_pkg.sv
// ============================================================================
// rc4_pkg
// Shared widths, register indexes and controller/datapath command types.
// ============================================================================
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int IDX_W         = 8;
    localparam int KEY_WORD_W    = 64;
    localparam int NUM_KEY_WORDS = 4;
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_IDX_W     = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx REG_KEY_WORD0  = 3'd0;
    localparam t_cfg_idx REG_KEY_WORD1  = 3'd1;
    localparam t_cfg_idx REG_KEY_WORD2  = 3'd2;
    localparam t_cfg_idx REG_KEY_WORD3  = 3'd3;
    localparam t_cfg_idx REG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the input beat
        logic init_wr;     // fill one entry with the identity
        logic ksa_rd_n;    // schedule: read entry n
        logic ksa_rd_acc;  // schedule: update acc, read entry acc
        logic ksa_wr_n;    // schedule: write entry n
        logic ksa_wr_acc;  // schedule: write entry acc, advance n
        logic prga_issue;  // keystream: advance i, read entry i
        logic prga_rd_j;   // keystream: advance j, read entry j
        logic prga_swap;   // keystream: write entry i, read keystream entry
        logic prga_fin;    // keystream: write entry j
        logic load_out;    // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_last;      // schedule counter at its last entry
        logic out_free;    // output register can take a beat this cycle
    } t_sts;

endpackage

// File: src/rc4_in_if.sv
// ============================================================================
// rc4_in_if
// Input channel: one data byte and its end-of-message flag per beat.
// ============================================================================
`timescale 1ns / 1ps

interface rc4_in_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_in_message;

    modport source (output valid, output data_byte, output last_in_message, input ready);
    modport sink   (input valid, input data_byte, input last_in_message, output ready);
endinterface

// File: src/rc4_out_if.sv
// ============================================================================
// rc4_out_if
// Output channel: one transformed byte and its end-of-message flag per beat.
// ============================================================================
`timescale 1ns / 1ps

interface rc4_out_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: src/rc4_ram.sv
// ============================================================================
// rc4_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                       o_rdata_a,
    input  logic                                   i_re_b,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                       o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write, and register read data; read data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: src/rc4_ctrl.sv
// ============================================================================
// rc4_ctrl
// Controller: sequences the key schedule and the per-byte keystream steps.
// ============================================================================
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  rc4_pkg::t_sts i_sts,
    output rc4_pkg::t_cmd o_cmd
);
    import rc4_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INIT     = 10'b00_0000_0010,
        S_K_RDN    = 10'b00_0000_0100,
        S_K_RDACC  = 10'b00_0000_1000,
        S_K_WRN    = 10'b00_0001_0000,
        S_K_WRACC  = 10'b00_0010_0000,
        S_P_ISSUE  = 10'b00_0100_0000,
        S_P_RDJ    = 10'b00_1000_0000,
        S_P_SWAP   = 10'b01_0000_0000,
        S_P_FIN    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_need_sched;
    logic   accept;

    // Take a beat when idle, or in the last step of a byte if the result can leave
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_P_FIN) && i_sts.out_free);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.accept = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_need_sched) begin
                        n_state = S_INIT;
                    end else begin
                        o_cmd.prga_issue = 1'b1;
                        n_state          = S_P_RDJ;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.n_last) begin
                    n_state = S_K_RDN;
                end
            end
            S_K_RDN: begin
                o_cmd.ksa_rd_n = 1'b1;
                n_state        = S_K_RDACC;
            end
            S_K_RDACC: begin
                o_cmd.ksa_rd_acc = 1'b1;
                n_state          = S_K_WRN;
            end
            S_K_WRN: begin
                o_cmd.ksa_wr_n = 1'b1;
                n_state        = S_K_WRACC;
            end
            S_K_WRACC: begin
                o_cmd.ksa_wr_acc = 1'b1;
                n_state          = i_sts.n_last ? S_P_ISSUE : S_K_RDN;
            end
            S_P_ISSUE: begin
                o_cmd.prga_issue = 1'b1;
                n_state          = S_P_RDJ;
            end
            S_P_RDJ: begin
                o_cmd.prga_rd_j = 1'b1;
                n_state         = S_P_SWAP;
            end
            S_P_SWAP: begin
                o_cmd.prga_swap = 1'b1;
                n_state         = S_P_FIN;
            end
            S_P_FIN: begin
                o_cmd.prga_fin = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (accept) begin
                        if (r_need_sched) begin
                            n_state = S_INIT;
                        end else begin
                            o_cmd.prga_issue = 1'b1;
                            n_state          = S_P_RDJ;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state; a message end means the next byte reschedules
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_need_sched <= 1'b1;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_need_sched <= i_in_last;
            end
        end
    end

`ifndef SYNTHESIS
    a_sched_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_need_sched) |=> (r_state == S_INIT))
        else $error("byte needing a schedule did not start one");

    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_RDJ) |=> (r_state == S_P_SWAP) ##1 (r_state == S_P_FIN))
        else $error("keystream steps out of order");

    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_K_WRACC) && i_sts.n_last) |=> (r_state == S_P_ISSUE))
        else $error("schedule did not hand over to the keystream");
`endif

endmodule

// File: src/rc4_dp.sv
// ============================================================================
// rc4_dp
// Datapath: key registers, permutation RAM, swap indices and output register.
// ============================================================================
`timescale 1ns / 1ps

module rc4_dp #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  rc4_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [rc4_pkg::KEY_WORD_W-1:0]     i_cfg_wdata,
    input  rc4_pkg::t_cmd                      i_cmd,
    output rc4_pkg::t_sts                      o_sts,
    input  logic [rc4_pkg::BYTE_W-1:0]         i_in_data,
    input  logic                               i_in_last,
    output logic                               o_out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_out_last,
    input  logic                               i_out_ready
);
    import rc4_pkg::*;

    localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
    localparam int KEY_BYTES = KEY_WORDS * 8;
    localparam int KB_W      = $clog2(KEY_BYTES);
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    logic [KEY_WORD_W-1:0] r_key_word [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic [BYTE_W-1:0]     key_bytes [KEY_BYTES];
    logic [KEY_LEN_W-1:0]  len_eff;
    logic [BYTE_W-1:0]     key_sel;
    logic                  kidx_wrap;

    logic [IDX_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_acc;
    logic [KB_W-1:0]   r_kidx;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [BYTE_W-1:0] r_si;
    logic [BYTE_W-1:0] r_sj;
    logic [IDX_W-1:0]  r_k;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_d;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              re_a;
    logic [IDX_W-1:0]  addr_a;
    logic [BYTE_W-1:0] rdata_a;
    logic              re_b;
    logic [IDX_W-1:0]  addr_b;
    logic [BYTE_W-1:0] rdata_b;

    logic [IDX_W-1:0]  acc_next;
    logic [IDX_W-1:0]  i_next;
    logic [IDX_W-1:0]  j_next;
    logic [IDX_W-1:0]  k_next;
    logic [BYTE_W-1:0] si_sel;
    logic [BYTE_W-1:0] ks;

    // Configuration writes; words above the key size are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
                r_key_word[w] <= '0;
            end
            r_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_we) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
                if (i_cfg_idx == REG_KEY_WORD0 + CFG_IDX_W'(w)) begin
                    r_key_word[w] <= i_cfg_wdata;
                end
            end
            if (i_cfg_idx == REG_KEY_LENGTH) begin
                r_key_len <= i_cfg_wdata[KEY_LEN_W-1:0];
            end
        end
    end

    // Split key words into bytes and pick the current one
    always_comb begin
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_bytes[b] = r_key_word[b / 8][(b % 8) * BYTE_W +: BYTE_W];
        end
    end
    assign key_sel = key_bytes[r_kidx];

    // Clamp the key length to 1..MAX_KEY_BYTES
    always_comb begin
        if (r_key_len == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (r_key_len > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = r_key_len;
        end
    end
    assign kidx_wrap = (KEY_LEN_W'(r_kidx) + KEY_LEN_W'(1)) == len_eff;

    // Index arithmetic, all modulo 256
    assign acc_next = r_acc + rdata_a + key_sel;
    assign i_next   = r_i + IDX_W'(1);
    assign si_sel   = r_fwd ? r_fwd_d : rdata_a;
    assign j_next   = r_j + si_sel;
    assign k_next   = r_si + rdata_b;

    // Keystream byte: forward the swapped entries still in flight
    always_comb begin
        if (r_k == r_j) begin
            ks = r_si;
        end else if (r_k == r_i) begin
            ks = r_sj;
        end else begin
            ks = rdata_a;
        end
    end

    // RAM port selection
    always_comb begin
        ram_we    = i_cmd.init_wr | i_cmd.ksa_wr_n | i_cmd.ksa_wr_acc |
                    i_cmd.prga_swap | i_cmd.prga_fin;
        ram_waddr = r_n;
        ram_wdata = r_n;
        if (i_cmd.ksa_wr_n) begin
            ram_waddr = r_n;
            ram_wdata = rdata_b;
        end else if (i_cmd.ksa_wr_acc) begin
            ram_waddr = r_acc;
            ram_wdata = r_si;
        end else if (i_cmd.prga_swap) begin
            ram_waddr = r_i;
            ram_wdata = rdata_b;
        end else if (i_cmd.prga_fin) begin
            ram_waddr = r_j;
            ram_wdata = r_si;
        end

        re_a = i_cmd.ksa_rd_n | i_cmd.prga_swap | i_cmd.prga_issue;
        if (i_cmd.ksa_rd_n) begin
            addr_a = r_n;
        end else if (i_cmd.prga_swap) begin
            addr_a = k_next;
        end else begin
            addr_a = i_next;
        end

        re_b   = i_cmd.ksa_rd_acc | i_cmd.prga_rd_j;
        addr_b = i_cmd.ksa_rd_acc ? acc_next : j_next;
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (re_a),
        .i_raddr_a (addr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (re_b),
        .i_raddr_b (addr_b),
        .o_rdata_b (rdata_b)
    );

    // Schedule counters and swap indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_fwd <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_n    <= r_n + IDX_W'(1);
                r_acc  <= '0;
                r_kidx <= '0;
            end
            if (i_cmd.ksa_rd_acc) begin
                r_acc <= acc_next;
                r_si  <= rdata_a;
            end
            if (i_cmd.ksa_wr_acc) begin
                r_n    <= r_n + IDX_W'(1);
                r_kidx <= kidx_wrap ? '0 : r_kidx + KB_W'(1);
                if (r_n == '1) begin
                    r_i <= '0;
                    r_j <= '0;
                end
            end
            if (i_cmd.prga_issue) begin
                r_i     <= i_next;
                r_fwd   <= i_cmd.prga_fin && (i_next == r_j);
                r_fwd_d <= r_si;
            end
            if (i_cmd.prga_rd_j) begin
                r_si <= si_sel;
                r_j  <= j_next;
            end
            if (i_cmd.prga_swap) begin
                r_sj <= rdata_b;
                r_k  <= k_next;
            end
        end
    end

    // Hold the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data <= i_in_data;
            r_last <= i_in_last;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_byte <= r_data ^ ks;
            r_out_last <= r_last;
        end
    end

    assign o_sts.n_last   = (r_n == '1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending beat");

    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ksa_wr_acc && (r_n == '1)) |=> ((r_i == '0) && (r_j == '0)))
        else $error("swap indices not cleared at schedule end");
`endif

endmodule

// File: src/rc4_stream_cipher.sv
// ============================================================================
// rc4_stream_cipher
// RC4 byte cipher. Write the key words (index 0..3) and key_length (index 4)
// through the config port while the block is idle. Send bytes on i_in; each
// comes back XORed with the next keystream byte on o_out, with its last flag.
// The first byte after reset or after a byte flagged last runs the key
// schedule first: an identity fill of all 256 entries, then the swaps
// (four RAM accesses per entry), then an index step, before its keystream
// steps. Other bytes take the index step in the cycle they are accepted,
// then read j, swap and finish; the next byte can be taken in the finish
// step. The read, read, swap chain on the single-write permutation RAM
// sets the byte rate. Results sit in an output register; when
// the receiver stalls, the block holds its last step with ready low until
// the pending beat leaves. Reset clears the key words, sets the key length
// to 16 and makes the next byte start a schedule.
// ============================================================================
`timescale 1ns / 1ps

module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rc4_in_if.sink                         i_in,
    rc4_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  rc4_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [rc4_pkg::KEY_WORD_W-1:0] i_cfg_wdata
);
    import rc4_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence schedule and keystream steps
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_in_message),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Key, permutation and result datapath
    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in.data_byte),
        .i_in_last   (i_in.last_in_message),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.out_last),
        .i_out_ready (o_out.ready)
    );

endmodule
